[rtl/core/lgs_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_pkg
// Shared types and constants for the Life generation stencil.
// ----------------------------------------------------------------------------
package lgs_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH_IN_USE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_IN_USE = 2'd1;

  localparam logic [CFG_DATA_W-1:0] CFG_SIZE_RESET = 9'd256;

  // 3x3 window: bits 0..2 top row, 3..5 middle, 6..8 bottom; bit 2 of a row is newest
  localparam int WIN_W      = 9;
  localparam int CENTRE_BIT = 4;

  localparam logic [WIN_W-1:0] MASK_TOP_ROW   = 9'h007;
  localparam logic [WIN_W-1:0] MASK_BOT_ROW   = 9'h1C0;
  localparam logic [WIN_W-1:0] MASK_LEFT_COL  = 9'h049;
  localparam logic [WIN_W-1:0] MASK_RIGHT_COL = 9'h124;
  localparam logic [WIN_W-1:0] MASK_CENTRE    = 9'h010;

  // B3/S23 neighbour counts
  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // Per-item position info carried down the pipe
  typedef struct packed {
    logic has_result;  // item yields a result
    logic last;        // result is the final cell of the frame
    logic edge_top;    // result cell sits on the first row
    logic edge_bot;    // result cell sits on the last row
    logic edge_left;   // result cell sits in the first column
    logic edge_right;  // result cell sits in the last column
  } pos_info_t;

endpackage : lgs_pkg
`default_nettype wire

[rtl/core/life_generation_stencil.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// life_generation_stencil
// One generation of Life (B3/S23) over a streamed raster grid.
// ----------------------------------------------------------------------------
// Usage:
//   Cells of the current generation enter on the in channel (valid/ready) in
//   raster order, one item per cycle unless stalled. Once a whole grid is in,
//   send width+1 flush items; any item after the last grid cell is a flush.
//   Each item from position width+1 on yields one result on the out channel:
//   the next state of the cell width+1 positions back, row-major from cell 0.
//   The final grid cell's result carries last_of_frame; the next item then
//   starts a new frame.
// Pipeline:
//   stage 1, stage 2 and the output register; one item per cycle sustained
//   unless stalled. The line stores are read one stage ahead of the window
//   update, and a read/write collision on the same column is forwarded.
// Stall:
//   the whole pipe holds while out_valid is high and out_ready low; in_ready
//   is low in exactly those cycles.
// Reset:
//   width and height go to 256, frame counters and window clear, pipe empties.
//   Line stores are not cleared; unwritten entries only reach masked cells.
// Configuration:
//   cfg_ready is always high; a write to a known index restarts the frame.
// ----------------------------------------------------------------------------
module life_generation_stencil import lgs_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration write
  input  wire logic                  cfg_valid,
  output      logic                  cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // cell input
  input  wire logic                  in_valid,
  output      logic                  in_ready,
  input  wire logic                  cell_alive,
  input  wire logic                  flush,
  // result output
  output      logic                  out_valid,
  input  wire logic                  out_ready,
  output      logic                  next_alive,
  output      logic                  last_of_frame
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [CFG_DATA_W-1:0] width_in_use;
  logic [CFG_DATA_W-1:0] height_in_use;
  logic                  restart;

  logic                  en;
  logic                  step;

  // sequencer outputs for the item being accepted
  logic [CW-1:0]         seq_col;
  logic                  seq_v;
  pos_info_t             seq_info;

  // stage 1: line store read issued
  logic                  s1_valid;
  logic [CW-1:0]         s1_col;
  logic                  s1_v;
  pos_info_t             s1_info;

  // stage 2: read data back, window slides
  logic                  s2_valid;
  logic [CW-1:0]         s2_col;
  logic                  s2_v;
  pos_info_t             s2_info;

  logic [WIN_W-1:0]      win_new;
  logic                  rule_alive;

  // config registers
  assign cfg_ready = 1'b1;
  assign restart   = cfg_valid && (cfg_index == REG_WIDTH_IN_USE ||
                                   cfg_index == REG_HEIGHT_IN_USE);

  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use  <= CFG_SIZE_RESET;
      height_in_use <= CFG_SIZE_RESET;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_WIDTH_IN_USE:  width_in_use  <= cfg_data;
        REG_HEIGHT_IN_USE: height_in_use <= cfg_data;
        default: ;
      endcase
    end
  end

  // whole pipe moves together; output register is the only stall point
  assign en       = !out_valid || out_ready;
  assign in_ready = en;
  assign step     = in_valid && in_ready;

  lgs_sequencer #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_sequencer (
    .clk        (clk),
    .rst        (rst),
    .restart    (restart),
    .width_cfg  (width_in_use),
    .height_cfg (height_in_use),
    .step       (step),
    .cell_alive (cell_alive),
    .flush      (flush),
    .col        (seq_col),
    .cell_v     (seq_v),
    .info       (seq_info)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= step;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_col  <= seq_col;
      s1_v    <= seq_v;
      s1_info <= seq_info;
      s2_col  <= s1_col;
      s2_v    <= s1_v;
      s2_info <= s1_info;
    end
  end

  lgs_line_window #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_window (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .rd_valid (s1_valid),
    .rd_col   (s1_col),
    .wr_valid (s2_valid),
    .wr_col   (s2_col),
    .wr_v     (s2_v),
    .win_new  (win_new)
  );

  lgs_rule u_rule (
    .win        (win_new),
    .info       (s2_info),
    .next_alive (rule_alive)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= s2_valid && s2_info.has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      next_alive    <= rule_alive;
      last_of_frame <= s2_info.last;
    end
  end

endmodule : life_generation_stencil
`default_nettype wire

[rtl/core/lgs_sequencer.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_sequencer
// Raster position counters for input and result cells of one frame.
// ----------------------------------------------------------------------------
module lgs_sequencer import lgs_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  restart,
  input  wire logic [CFG_DATA_W-1:0] width_cfg,
  input  wire logic [CFG_DATA_W-1:0] height_cfg,
  input  wire logic                  step,
  input  wire logic                  cell_alive,
  input  wire logic                  flush,
  output      logic [CW-1:0]         col,
  output      logic                  cell_v,
  output      pos_info_t             info
);

  localparam int WVW = $clog2(MAX_WIDTH + 1);
  localparam int HVW = $clog2(MAX_HEIGHT + 1);
  localparam int RW  = $clog2(MAX_HEIGHT + 2);
  localparam int ORW = $clog2(MAX_HEIGHT);

  logic [WVW-1:0] w_eff;
  logic [HVW-1:0] h_eff;
  logic [CW-1:0]  col_cnt;
  logic [RW-1:0]  row_cnt;
  logic [CW-1:0]  ocol;
  logic [ORW-1:0] orow;
  logic           col_wrap;
  logic           in_grid;

  // zero acts as one, oversize saturates
  always_comb begin
    if (width_cfg == '0) begin
      w_eff = WVW'(1);
    end else if (32'(width_cfg) > 32'(MAX_WIDTH)) begin
      w_eff = WVW'(MAX_WIDTH);
    end else begin
      w_eff = WVW'(width_cfg);
    end
    if (height_cfg == '0) begin
      h_eff = HVW'(1);
    end else if (32'(height_cfg) > 32'(MAX_HEIGHT)) begin
      h_eff = HVW'(MAX_HEIGHT);
    end else begin
      h_eff = HVW'(height_cfg);
    end
  end

  assign col_wrap = (WVW'(col_cnt) + WVW'(1)) == w_eff;
  assign in_grid  = row_cnt < RW'(h_eff);

  // results start once the input is width+1 cells ahead
  assign info.has_result = (row_cnt >= RW'(2)) || (row_cnt == RW'(1) && col_cnt != '0);
  assign info.edge_top   = orow == '0;
  assign info.edge_bot   = (HVW'(orow) + HVW'(1)) == h_eff;
  assign info.edge_left  = ocol == '0;
  assign info.edge_right = (WVW'(ocol) + WVW'(1)) == w_eff;
  assign info.last       = info.edge_bot && info.edge_right;

  assign col    = col_cnt;
  assign cell_v = in_grid && !flush && cell_alive;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      col_cnt <= '0;
      row_cnt <= '0;
      ocol    <= '0;
      orow    <= '0;
    end else if (step) begin
      if (info.has_result && info.last) begin
        col_cnt <= '0;
        row_cnt <= '0;
        ocol    <= '0;
        orow    <= '0;
      end else begin
        if (col_wrap) begin
          col_cnt <= '0;
          row_cnt <= row_cnt + RW'(1);
        end else begin
          col_cnt <= col_cnt + CW'(1);
        end
        if (info.has_result) begin
          if (info.edge_right) begin
            ocol <= '0;
            orow <= orow + ORW'(1);
          end else begin
            ocol <= ocol + CW'(1);
          end
        end
      end
    end
  end

endmodule : lgs_sequencer
`default_nettype wire

[rtl/core/lgs_line_window.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_line_window
// Two line stores and the sliding 3x3 neighbour window.
// ----------------------------------------------------------------------------
module lgs_line_window import lgs_pkg::*; #(
  parameter int MAX_WIDTH = 256,
  localparam int CW = $clog2(MAX_WIDTH)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire logic             rd_valid,
  input  wire logic [CW-1:0]    rd_col,
  input  wire logic             wr_valid,
  input  wire logic [CW-1:0]    wr_col,
  input  wire logic             wr_v,
  output      logic [WIN_W-1:0] win_new
);

  logic upper_mem  [MAX_WIDTH];
  logic middle_mem [MAX_WIDTH];

  logic             top_raw;
  logic             mid_raw;
  logic             byp;
  logic             byp_top;
  logic             byp_mid;
  logic             top_cur;
  logic             mid_cur;
  logic [WIN_W-1:0] window;

  // read first: a write to the address read in the same cycle is forwarded
  assign top_cur = byp ? byp_top : top_raw;
  assign mid_cur = byp ? byp_mid : mid_raw;

  always_ff @(posedge clk) begin
    if (en && wr_valid) begin
      upper_mem[wr_col]  <= mid_cur;
      middle_mem[wr_col] <= wr_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      top_raw <= upper_mem[rd_col];
      mid_raw <= middle_mem[rd_col];
      byp_top <= mid_cur;
      byp_mid <= wr_v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byp    <= 1'b0;
      window <= '0;
    end else if (en) begin
      byp <= rd_valid && wr_valid && (rd_col == wr_col);
      if (wr_valid) begin
        window <= win_new;
      end
    end
  end

  assign win_new = {wr_v, window[8:7], mid_cur, window[5:4], top_cur, window[2:1]};

endmodule : lgs_line_window
`default_nettype wire

[rtl/core/lgs_rule.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_rule
// Edge masking, neighbour count and the B3/S23 decision.
// ----------------------------------------------------------------------------
module lgs_rule import lgs_pkg::*; (
  input  wire logic [WIN_W-1:0] win,
  input  wire pos_info_t        info,
  output      logic             next_alive
);

  logic [WIN_W-1:0] masked;
  logic [3:0]       count;
  logic             centre;

  always_comb begin
    masked = win;
    if (info.edge_top)   masked = masked & ~MASK_TOP_ROW;
    if (info.edge_bot)   masked = masked & ~MASK_BOT_ROW;
    if (info.edge_left)  masked = masked & ~MASK_LEFT_COL;
    if (info.edge_right) masked = masked & ~MASK_RIGHT_COL;
  end

  assign centre = masked[CENTRE_BIT];

  always_comb begin
    count = '0;
    for (int i = 0; i < WIN_W; i++) begin
      count = count + 4'((masked & ~MASK_CENTRE) >> i) % 4'd2;
    end
  end

  assign next_alive = (count == BIRTH_COUNT) || (centre && count == SURVIVE_COUNT);

endmodule : lgs_rule
`default_nettype wire

[rtl/core/lgs_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lgs_checker
// Port-level checks for the Life generation stencil.
// ----------------------------------------------------------------------------
module lgs_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic next_alive,
  input wire logic last_of_frame
);

  // a stalled result stays put
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(next_alive) && $stable(last_of_frame))
    else $error("result changed while stalled");

  // empty output register means the block takes an item
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("in_ready low with empty output");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  // a new result is only loaded on an edge where the pipe moved
  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_ready))
    else $error("result loaded while the pipe was held");

endmodule : lgs_checker

bind life_generation_stencil lgs_checker u_lgs_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .next_alive    (next_alive),
  .last_of_frame (last_of_frame)
);
`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for life_generation_stencil. Cells of random Life
// grids stream in through a gapped driver; a behavioral predictor
// advances its own line stores and 3x3 window per accepted item and queues
// the next-generation state of each finished cell. The monitor pops that
// queue for every result the block hands over, with random stalls and two
// long hold-offs on the result side.
// ----------------------------------------------------------------------------
module testbench;
  import lgs_pkg::*;

  localparam int unsigned GRID_MAX            = 256;
  localparam int unsigned SETTLE_CYCLES       = 8;      // pipe is 3 deep
  localparam int unsigned LONG_HOLD_CYCLES    = 300;
  localparam int unsigned RANDOM_ITEMS_TARGET = 1250;
  localparam int unsigned MAX_REPORTS         = 40;

  // register indexes past the end of the map: writes there are ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  // neighbour window: bits 0..2 top row, 3..5 middle, 6..8 bottom
  localparam logic [8:0] TOP_ROW_CELLS    = 9'h007;
  localparam logic [8:0] BOTTOM_ROW_CELLS = 9'h1C0;
  localparam logic [8:0] LEFT_COL_CELLS   = 9'h049;
  localparam logic [8:0] RIGHT_COL_CELLS  = 9'h124;
  localparam int unsigned CENTRE_CELL     = 4;

  typedef struct {
    logic alive;
    logic flush;
  } cell_item_t;

  typedef struct {
    logic next_alive;
    logic last;
  } gen_result_t;

  // DUT signals; every input starts at a known value
  logic                  clk        = 1'b0;
  logic                  rst        = 1'b1;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic                  cell_alive = 1'b0;
  logic                  flush      = 1'b0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic                  next_alive;
  logic                  last_of_frame;

  // stimulus side
  cell_item_t      cells_to_send[$];
  cell_item_t      send_item;
  int unsigned     queued_count   = 0;
  int unsigned     accepted_count = 0;
  int unsigned     results_seen   = 0;
  int unsigned     fail_count     = 0;
  logic            in_fire        = 1'b0;
  int unsigned     send_gap       = 0;
  int unsigned     send_calm      = 0;
  int unsigned     recv_pause     = 0;
  int unsigned     recv_calm      = 0;
  logic            long_hold      = 1'b0;
  logic [CFG_DATA_W-1:0] cfg_w_raw = CFG_SIZE_RESET;  // what the stimulus last wrote
  logic [CFG_DATA_W-1:0] cfg_h_raw = CFG_SIZE_RESET;

  // predictor state
  gen_result_t           next_gen_q[$];
  logic                  row_two_up [GRID_MAX];
  logic                  row_one_up [GRID_MAX];
  logic [8:0]            nbr_window;
  int unsigned           col_at;
  int unsigned           row_at;
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;

  life_generation_stencil uut (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .cell_alive    (cell_alive),
    .flush         (flush),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .next_alive    (next_alive),
    .last_of_frame (last_of_frame)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // sync reset, released on a falling edge
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  initial begin
    #10_000_000;
    $display("testbench failed");
    $finish;
  end

  // Register value as the block uses it: 0 means 1, above 256 means 256.
  function automatic int unsigned eff_size(input logic [CFG_DATA_W-1:0] raw);
    if (raw == 0) return 1;
    if (raw > GRID_MAX) return GRID_MAX;
    return 32'(raw);
  endfunction

  // Idle length for either side: mostly none or short, now and then long.
  // While calm is running there is no idling at all.
  function automatic int unsigned next_pause(inout int unsigned calm);
    int unsigned roll;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) calm = $urandom_range(30, 150);
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // --------------------------------------------------------------------------
  // Next-generation predictor. Runs once per accepted item: slides the line
  // stores and the window, and once the window centre is a real grid cell
  // (width+1 items into the frame) queues that cell's B3/S23 outcome.
  // --------------------------------------------------------------------------
  task automatic predict_cell(input logic alive_in, input logic flush_in);
    int unsigned w, h, total, col, pos, q, orow, ocol, n;
    logic        v, top, mid, centre;
    logic [8:0]  win;
    gen_result_t r;
    w     = eff_size(width_reg);
    h     = eff_size(height_reg);
    total = w * h;
    col   = col_at % w;
    pos   = row_at * w + col;
    // flushes and anything past the last grid cell enter as dead cells
    v     = (pos < total && !flush_in) ? alive_in : 1'b0;
    top   = row_two_up[col];
    mid   = row_one_up[col];
    row_two_up[col] = mid;
    row_one_up[col] = v;
    // each row shifts toward bit 0; the newest column lands in bit 2 of a row
    nbr_window = {v, nbr_window[8:7], mid, nbr_window[5:4], top, nbr_window[2:1]};
    col++;
    if (col >= w) begin
      col = 0;
      row_at++;
    end
    col_at = col;
    if (pos < w + 1) return;
    q    = pos - w - 1;
    orow = q / w;
    ocol = q % w;
    win  = nbr_window;
    // neighbours off the grid are dead
    if (orow == 0) win &= ~TOP_ROW_CELLS;
    if (orow + 1 >= h) win &= ~BOTTOM_ROW_CELLS;
    if (ocol == 0) win &= ~LEFT_COL_CELLS;
    if (ocol + 1 >= w) win &= ~RIGHT_COL_CELLS;
    centre = win[CENTRE_CELL];
    win[CENTRE_CELL] = 1'b0;
    n = $countones(win);
    r.next_alive = (n == 3) || (centre && n == 2);
    r.last       = (q + 1 >= total);
    next_gen_q.push_back(r);
    if (r.last) begin
      col_at = 0;
      row_at = 0;
    end
  endtask

  // --------------------------------------------------------------------------
  // Monitor: everything is sampled on the rising edge. The prediction for an
  // item accepted this edge is queued before any result is checked.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    gen_result_t want;
    if (rst) begin
      in_fire    = 1'b0;
      width_reg  = CFG_SIZE_RESET;
      height_reg = CFG_SIZE_RESET;
      nbr_window = '0;
      col_at     = 0;
      row_at     = 0;
      for (int i = 0; i < GRID_MAX; i++) begin
        row_two_up[i] = 1'b0;
        row_one_up[i] = 1'b0;
      end
    end else begin
      in_fire = in_valid && in_ready;
      // a write to a real register restarts the frame; the stores are kept
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_WIDTH_IN_USE) begin
          width_reg = cfg_data;
          col_at    = 0;
          row_at    = 0;
        end else if (cfg_index == REG_HEIGHT_IN_USE) begin
          height_reg = cfg_data;
          col_at     = 0;
          row_at     = 0;
        end
      end
      if (in_fire) begin
        predict_cell(cell_alive, flush);
        accepted_count++;
      end
      if (out_valid && out_ready) begin
        results_seen++;
        if (next_gen_q.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("%0t: result with none expected: next_alive %0b last_of_frame %0b",
                     $time, next_alive, last_of_frame);
        end else begin
          want = next_gen_q.pop_front();
          if (next_alive !== want.next_alive) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: next_alive expected %0b got %0b",
                       $time, want.next_alive, next_alive);
          end
          if (last_of_frame !== want.last) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("%0t: last_of_frame expected %0b got %0b",
                       $time, want.last, last_of_frame);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Cell driver: on the falling edge, either holds the current item or, once
  // it was taken, idles for the drawn gap and then presents the next one.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (cells_to_send.size() != 0) begin
        send_item = cells_to_send.pop_front();
        in_valid   <= 1'b1;
        cell_alive <= send_item.alive;
        flush      <= send_item.flush;
        send_gap = next_pause(send_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side: random stalls, plus the long hold-offs below.
  always @(negedge clk) begin
    if (long_hold || recv_pause > 0) begin
      out_ready <= 1'b0;
      if (recv_pause > 0) recv_pause--;
    end else begin
      out_ready <= 1'b1;
      recv_pause = next_pause(recv_calm);
    end
  end

  // Long hold-offs on the result side while cells keep coming: the pipe
  // fills and in_ready has to drop. One lands inside the wide frame, one
  // inside the tall one.
  initial begin : result_hold
    int unsigned trigger;
    trigger = 150;
    repeat (2) begin
      wait (results_seen >= trigger);
      @(posedge clk);
      long_hold = 1'b1;
      repeat (LONG_HOLD_CYCLES) @(posedge clk);
      long_hold = 1'b0;
      trigger = 450;
    end
  end

  task automatic queue_item(input logic alive, input logic flush_bit);
    cell_item_t c;
    c.alive = alive;
    c.flush = flush_bit;
    cells_to_send.push_back(c);
    queued_count++;
  endtask

  // Frame positions [from_pos, to_pos) at the current size with random
  // cells. Inside the grid a few items are flushes (dead cells); in the
  // drain some carry a plain cell, which the block must treat as a flush.
  task automatic push_cells(input int unsigned from_pos, input int unsigned to_pos);
    int unsigned w, h, density;
    w = eff_size(cfg_w_raw);
    h = eff_size(cfg_h_raw);
    density = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) * 100
                                          : $urandom_range(10, 90);
    @(posedge clk);
    for (int unsigned p = from_pos; p < to_pos; p++) begin
      if (p < w * h)
        queue_item($urandom_range(0, 99) < density, $urandom_range(0, 99) < 4);
      else
        queue_item(1'($urandom_range(0, 1)), $urandom_range(0, 4) != 0);
    end
  endtask

  // Every queued item accepted, every result back, then a settle wait so
  // items that give no result have left the pipe.
  task automatic wait_idle();
    do @(negedge clk);
    while (accepted_count != queued_count || next_gen_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    if (idx == REG_WIDTH_IN_USE) cfg_w_raw = val;
    else if (idx == REG_HEIGHT_IN_USE) cfg_h_raw = val;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Stimulus: directed grids first, then one full-width and one full-height
  // frame, then random small grids. Registers only change while idle.
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [8:0]  blinker;
    int unsigned pick, wr, hr, frame_len, style, cut, phase_no;
    blinker  = 9'b010_010_010;  // vertical bar in the middle column
    phase_no = 0;
    wait (!rst);
    wait_idle();

    // 3x3 blinker: bar turns horizontal; covers birth, survival and death.
    // First drain item carries a live plain cell that must be ignored.
    write_reg(REG_WIDTH_IN_USE, 9'd3);
    write_reg(REG_HEIGHT_IN_USE, 9'd3);
    @(posedge clk);
    for (int p = 0; p < 9; p++) queue_item(blinker[p], 1'b0);
    queue_item(1'b1, 1'b0);
    queue_item(1'b0, 1'b1);
    queue_item(1'b1, 1'b1);
    queue_item(1'b0, 1'b1);
    wait_idle();

    // zero in both registers means a 1x1 grid; its only cell comes as a
    // live-looking flush, so it counts dead
    write_reg(REG_WIDTH_IN_USE, 9'd0);
    write_reg(REG_HEIGHT_IN_USE, 9'd0);
    @(posedge clk);
    queue_item(1'b1, 1'b1);
    queue_item(1'b1, 1'b0);
    queue_item(1'b0, 1'b1);
    wait_idle();

    // widest grid (value at or above 256), one row
    write_reg(REG_WIDTH_IN_USE, CFG_DATA_W'($urandom_range(256, 511)));
    write_reg(REG_HEIGHT_IN_USE, 9'd1);
    push_cells(0, GRID_MAX + GRID_MAX + 1);
    wait_idle();

    // tallest grid, one column
    write_reg(REG_WIDTH_IN_USE, 9'd1);
    write_reg(REG_HEIGHT_IN_USE, CFG_DATA_W'($urandom_range(256, 511)));
    push_cells(0, GRID_MAX + 2);

    while (queued_count < RANDOM_ITEMS_TARGET) begin
      wait_idle();
      pick = $urandom_range(0, 9);
      wr = (pick < 7) ? $urandom_range(0, 10) : $urandom_range(11, 24);
      hr = (pick < 7) ? $urandom_range(0, 10) : $urandom_range(0, 6);
      // the first random phase must drop the tall height
      case ((phase_no == 0) ? 2 : $urandom_range(0, 3))
        0: write_reg(REG_WIDTH_IN_USE, CFG_DATA_W'(wr));
        1: write_reg(REG_HEIGHT_IN_USE, CFG_DATA_W'(hr));
        default: begin
          write_reg(REG_WIDTH_IN_USE, CFG_DATA_W'(wr));
          write_reg(REG_HEIGHT_IN_USE, CFG_DATA_W'(hr));
        end
      endcase
      frame_len = eff_size(cfg_w_raw) * eff_size(cfg_h_raw) + eff_size(cfg_w_raw) + 1;
      // back-to-back frames need no restart in between
      repeat ($urandom_range(0, 2)) push_cells(0, frame_len);
      style = (phase_no < 2) ? phase_no : $urandom_range(0, 7);
      cut   = $urandom_range(1, frame_len - 1);
      if (style == 0) begin
        // abandon the frame; the next register write restarts it
        push_cells(0, cut);
      end else if (style == 1) begin
        // writes to unmapped indexes mid-frame must not disturb it
        push_cells(0, cut);
        wait_idle();
        write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
        push_cells(cut, frame_len);
      end else begin
        push_cells(0, frame_len);
      end
      phase_no++;
    end

    wait_idle();
    if (fail_count == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
